[hw/rtl/websocket_frame_deframer_macros.svh]
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

[hw/rtl/wsd_pkg.sv]
package wsd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_first;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] payload_byte;
		logic       is_text;
		logic       last_of_message;
	} out_beat_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_HDR2    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	localparam logic [2:0] EV_BYTE    = 3'd0;
	localparam logic [2:0] EV_EMPTY   = 3'd1;
	localparam logic [2:0] EV_CLOSE   = 3'd2;
	localparam logic [2:0] EV_TOOLONG = 3'd3;
	localparam logic [2:0] EV_CONT    = 3'd4;

	localparam logic [3:0] OPC_CONT  = 4'h0;
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_BIN   = 4'h2;
	localparam logic [3:0] OPC_CLOSE = 4'h8;

	localparam logic [6:0] LEN7_MAX   = 7'd125;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

endpackage

[hw/rtl/wsd_in_stage.sv]
module wsd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wsd_pkg::in_beat_t in_beat,
	input  logic              adv,
	output logic              valid_s1,
	output wsd_pkg::in_beat_t beat_s1
);
	import wsd_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

[hw/rtl/wsd_parser.sv]
module wsd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  wsd_pkg::in_beat_t  beat_s1,
	input  logic [31:0]        max_len,
	output logic               res_valid,
	output wsd_pkg::out_beat_t res
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opc_q, opc_d;
	logic        mask_q, mask_d;
	logic [3:0]  ext_q, ext_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [2:0]  keyl_q, keyl_d;
	logic [1:0]  midx_q, midx_d;
	logic        closed_q, closed_d;

	logic [7:0]  b;
	logic [6:0]  len7;
	logic        is_data;
	logic        txt;
	logic [7:0]  kb;

	assign b       = beat_s1.data_byte;
	assign len7    = b[6:0];
	assign is_data = (opc_q == OPC_TEXT) || (opc_q == OPC_BIN);
	assign txt     = (opc_q == OPC_TEXT);
	assign kb      = 8'(key_q >> {~midx_q, 3'b000});

	always_comb begin
		logic        lk;
		logic        hd;
		logic [63:0] lval;
		lk        = 1'b0;
		hd        = 1'b0;
		lval      = len_q;
		phase_d   = phase_q;
		fin_d     = fin_q;
		opc_d     = opc_q;
		mask_d    = mask_q;
		ext_d     = ext_q;
		len_d     = len_q;
		key_d     = key_q;
		keyl_d    = keyl_q;
		midx_d    = midx_q;
		closed_d  = closed_q;
		res_valid = 1'b0;
		res       = '0;

		if (closed_q) begin
			// closed until reset
		end else if (beat_s1.chunk_first) begin
			fin_d   = b[7];
			opc_d   = b[3:0];
			mask_d  = 1'b0;
			key_d   = '0;
			len_d   = '0;
			midx_d  = '0;
			ext_d   = '0;
			keyl_d  = '0;
			phase_d = PH_HDR2;
			if (b[3:0] == OPC_CLOSE) begin
				closed_d      = 1'b1;
				phase_d       = PH_IDLE;
				res_valid     = 1'b1;
				res.event_res = EV_CLOSE;
			end else if (b[3:0] == OPC_CONT) begin
				closed_d      = 1'b1;
				phase_d       = PH_IDLE;
				res_valid     = 1'b1;
				res.event_res = EV_CONT;
			end
		end else begin
			case (phase_q)
				PH_HDR2: begin
					mask_d = b[7];
					if (!is_data) begin
						phase_d = PH_IDLE;
					end else if (len7 <= LEN7_MAX) begin
						lk   = 1'b1;
						lval = {57'd0, len7};
					end else begin
						len_d   = '0;
						ext_d   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_d = PH_EXTLEN;
					end
				end
				PH_EXTLEN: begin
					lval  = {len_q[55:0], b};
					len_d = lval;
					ext_d = ext_q - 4'd1;
					lk    = (ext_q == 4'd1);
				end
				PH_KEY: begin
					key_d  = {key_q[23:0], b};
					keyl_d = keyl_q - 3'd1;
					hd     = (keyl_q == 3'd1);
				end
				PH_PAYLOAD: begin
					midx_d = midx_q + 2'd1;
					len_d  = len_q - 64'd1;
					if (len_q == 64'd1) begin
						phase_d = PH_IDLE;
					end
					if (fin_q) begin
						res_valid           = 1'b1;
						res.event_res       = EV_BYTE;
						res.payload_byte    = b ^ kb;
						res.is_text         = txt;
						res.last_of_message = (len_q == 64'd1);
					end
				end
				default: begin
					// stray byte outside a frame
				end
			endcase

			if (lk) begin
				len_d = lval;
				if ((lval[63:32] != 32'd0) || (lval[31:0] > max_len)) begin
					closed_d      = 1'b1;
					phase_d       = PH_IDLE;
					res_valid     = 1'b1;
					res.event_res = EV_TOOLONG;
					res.is_text   = txt;
				end else if (mask_d) begin
					keyl_d  = KEY_BYTES;
					phase_d = PH_KEY;
				end else begin
					hd = 1'b1;
				end
			end

			if (hd) begin
				midx_d = '0;
				if (lval == 64'd0) begin
					phase_d = PH_IDLE;
					if (fin_q) begin
						res_valid           = 1'b1;
						res.event_res       = EV_EMPTY;
						res.is_text         = txt;
						res.last_of_message = 1'b1;
					end
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fin_q    <= 1'b0;
			opc_q    <= '0;
			mask_q   <= 1'b0;
			ext_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			keyl_q   <= '0;
			midx_q   <= '0;
			closed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opc_q    <= opc_d;
			mask_q   <= mask_d;
			ext_q    <= ext_d;
			len_q    <= len_d;
			key_q    <= key_d;
			keyl_q   <= keyl_d;
			midx_q   <= midx_d;
			closed_q <= closed_d;
		end
	end

endmodule

[hw/rtl/wsd_out_stage.sv]
module wsd_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               res_valid,
	input  wsd_pkg::out_beat_t res,
	output logic               free,
	output logic               out_valid,
	input  logic               out_stall,
	output wsd_pkg::out_beat_t out_beat
);
	import wsd_pkg::*;

	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && step && res_valid) begin
			out_beat <= res;
		end
	end

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// channel | direction | handshake          | beat
// in      | receive   | in_valid/in_stall   | in_beat (data_byte, chunk_first)
// out     | send      | out_valid/out_stall | out_beat (event, byte, text, last)
// cfg     | receive   | cfg_we              | cfg_wdata (max payload length)
//
// One beat a cycle unless out_stall holds the output: input register, header/payload FSM, output register.
// A result passes the input register and then the output register before it shows on out_valid.
// arst_n clears the valid flags and all FSM state; max payload length returns to 65535.
// out_stall holds the output register and, through it, the input register.
module websocket_frame_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wsd_pkg::in_beat_t  in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output wsd_pkg::out_beat_t out_beat,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);
	import wsd_pkg::*;

	logic        free;
	logic        valid_s1;
	in_beat_t    beat_s1;
	logic        step;
	logic        res_valid;
	out_beat_t   res;
	logic [31:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign step = valid_s1 && free;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.adv      (free),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.beat_s1   (beat_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

[hw/rtl/wsd_checker.sv]
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input wsd_pkg::out_beat_t out_beat
);
	import wsd_pkg::*;

	`WSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))
	`WSD_ASSERT_NOW(a_ev_range, out_valid, (out_beat.event_res == EV_BYTE) || (out_beat.event_res == EV_EMPTY) || (out_beat.event_res == EV_CLOSE) || (out_beat.event_res == EV_TOOLONG) || (out_beat.event_res == EV_CONT))
	`WSD_ASSERT_NOW(a_byte_zero, out_valid && (out_beat.event_res != EV_BYTE), out_beat.payload_byte == 8'd0)
	`WSD_ASSERT_NOW(a_empty_last, out_valid && (out_beat.event_res == EV_EMPTY), out_beat.last_of_message)
	`WSD_ASSERT_NEXT(a_closed_quiet, out_valid && !out_stall && ((out_beat.event_res == EV_CLOSE) || (out_beat.event_res == EV_TOOLONG) || (out_beat.event_res == EV_CONT)), !out_valid)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_beat  (out_beat)
);
